// ===== rtl/wla_pkg.sv =====
`default_nettype none
package wla_pkg;

   localparam int QUEUE_LEN  = 64;
   localparam int RING_DEPTH = QUEUE_LEN - 1;
   localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(QUEUE_LEN);

   localparam int SAMPLE_W = 32;
   localparam int STAMP_W  = 48;
   localparam int PERIOD_W = 22;
   localparam int AVG_W    = 32;
   localparam int USED_W   = 6;
   localparam int ENTRY_W  = STAMP_W + SAMPLE_W;

   localparam int WSUM_MAX = RING_DEPTH * QUEUE_LEN / 2;
   localparam int DIVS_W   = $clog2(WSUM_MAX + 1);
   localparam int SUM_W    = SAMPLE_W + DIVS_W;
   localparam int STEP_MAX = (SUM_W > RING_DEPTH) ? SUM_W : RING_DEPTH;
   localparam int STEP_W   = $clog2(STEP_MAX + 1);

   localparam int REQ_DATA_W = ((SAMPLE_W + STAMP_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((AVG_W + USED_W + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = PERIOD_W;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_PERIOD = 1'b1;
   localparam logic [PERIOD_W-1:0]  PERIOD_RESET      = 22'd60000;

   typedef struct packed {
      logic load;
      logic issue;
      logic acc;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/wla_ctrl.sv =====
`default_nettype none
module wla_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output wla_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WALK  = 3'd1;
   localparam logic [2:0] S_DINIT = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [wla_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic                         out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            cmd.issue = (step_ff != wla_pkg::STEP_W'(wla_pkg::RING_DEPTH));
            cmd.acc   = (step_ff != '0);
            step_in   = step_ff + wla_pkg::STEP_W'(1);
            if (step_ff == wla_pkg::STEP_W'(wla_pkg::RING_DEPTH)) begin
               state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + wla_pkg::STEP_W'(1);
            if (step_ff == wla_pkg::STEP_W'(wla_pkg::SUM_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("result overwritten while stalled");

   a_walk_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_WALK && step_ff == '0))
      else $error("walk did not start after accept");

   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff == wla_pkg::STEP_W'(wla_pkg::SUM_W - 1))
      |=> (state_ff == S_DONE))
      else $error("divider step count wrong");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_tready)
      else $error("ready during ring walk");

endmodule
`default_nettype wire

// ===== rtl/wla_dpath.sv =====
`default_nettype none
module wla_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire wla_pkg::cmd_type                   cmd,
   input  wire logic [wla_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                               csr_wen,
   input  wire logic [wla_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [wla_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic      [wla_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic                                mode_ff;
   logic [wla_pkg::PERIOD_W-1:0]        period_ff;

   logic [wla_pkg::SAMPLE_W-1:0]        req_sample;
   logic [wla_pkg::STAMP_W-1:0]         req_now;
   logic [wla_pkg::STAMP_W-1:0]         thr_in, thr_ff;

   logic [wla_pkg::ENTRY_W-1:0]         ring_mem [wla_pkg::RING_DEPTH];
   logic [wla_pkg::RING_DEPTH-1:0]      vld_ff;
   logic [wla_pkg::PTR_W-1:0]           ptr_ff, ptr_nxt, rd_ptr_ff;
   logic [wla_pkg::ENTRY_W-1:0]         rd_entry_ff;
   logic                                rd_vld_ff;

   logic [wla_pkg::STAMP_W-1:0]         rd_stamp;
   logic [wla_pkg::SAMPLE_W-1:0]        rd_value;
   logic                                hit;
   logic [wla_pkg::CNT_W-1:0]           cnt_ff;
   logic [wla_pkg::CNT_W:0]             cnt_inc;
   logic [wla_pkg::SAMPLE_W+wla_pkg::CNT_W-1:0] prod;
   logic [wla_pkg::SUM_W-1:0]           term, sum_ff;

   logic [wla_pkg::DIVS_W:0]            pair_prod;
   logic [wla_pkg::DIVS_W-1:0]          divs_in, divs_ff;
   logic [wla_pkg::DIVS_W:0]            rem_ff, shifted;
   logic [wla_pkg::DIVS_W+1:0]          diff;
   logic                                ge;
   logic [wla_pkg::SUM_W-1:0]           quo_ff;

   logic [wla_pkg::AVG_W-1:0]           avg_ff;
   logic [wla_pkg::USED_W-1:0]          used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         period_ff <= wla_pkg::PERIOD_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            wla_pkg::CSR_AVERAGE_MODE:  mode_ff   <= csr_wdata[0];
            wla_pkg::CSR_WINDOW_PERIOD: period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_sample = req_tdata[wla_pkg::SAMPLE_W-1:0];
   assign req_now    = req_tdata[wla_pkg::SAMPLE_W +: wla_pkg::STAMP_W];

   // threshold saturates at zero; period zero means no age limit
   always_comb begin
      if (period_ff != '0 && req_now > wla_pkg::STAMP_W'(period_ff)) begin
         thr_in = req_now - wla_pkg::STAMP_W'(period_ff);
      end else begin
         thr_in = '0;
      end
   end

   assign ptr_nxt = wla_pkg::next_ptr(ptr_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ring_mem[ptr_ff] <= {req_now, req_sample};
      end
      if (cmd.issue) begin
         rd_entry_ff <= ring_mem[rd_ptr_ff];
      end
   end

   // unwritten slots have their valid bit clear and never count
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         ptr_ff <= '0;
      end else if (cmd.load) begin
         vld_ff[ptr_ff] <= 1'b1;
         ptr_ff         <= ptr_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_ptr_ff <= ptr_nxt;
      end else if (cmd.issue) begin
         rd_ptr_ff <= wla_pkg::next_ptr(rd_ptr_ff);
      end
      if (cmd.issue) begin
         rd_vld_ff <= vld_ff[rd_ptr_ff];
      end
   end

   assign rd_stamp = rd_entry_ff[wla_pkg::SAMPLE_W +: wla_pkg::STAMP_W];
   assign rd_value = rd_entry_ff[wla_pkg::SAMPLE_W-1:0];
   assign hit      = rd_vld_ff && (rd_stamp > thr_ff);
   assign cnt_inc  = {1'b0, cnt_ff} + (wla_pkg::CNT_W+1)'(1);
   assign prod     = (wla_pkg::SAMPLE_W+wla_pkg::CNT_W)'(rd_value)
                   * (wla_pkg::SAMPLE_W+wla_pkg::CNT_W)'(cnt_inc);
   assign term     = mode_ff ? wla_pkg::SUM_W'(prod) : wla_pkg::SUM_W'(rd_value);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         thr_ff <= thr_in;
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.acc && hit) begin
         cnt_ff <= cnt_inc[wla_pkg::CNT_W-1:0];
         sum_ff <= sum_ff + term;
      end
   end

   // weighted divisor is c(c+1)/2
   assign pair_prod = (wla_pkg::DIVS_W+1)'(cnt_ff) * (wla_pkg::DIVS_W+1)'(cnt_inc);
   assign divs_in   = mode_ff ? pair_prod[wla_pkg::DIVS_W:1]
                              : wla_pkg::DIVS_W'(cnt_ff);

   assign shifted = {rem_ff[wla_pkg::DIVS_W-1:0], quo_ff[wla_pkg::SUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divs_ff};
   assign ge      = !diff[wla_pkg::DIVS_W+1];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         divs_ff <= divs_in;
         rem_ff  <= '0;
         quo_ff  <= sum_ff;
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? diff[wla_pkg::DIVS_W:0] : shifted;
         quo_ff  <= {quo_ff[wla_pkg::SUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         avg_ff  <= (cnt_ff == '0) ? '0 : quo_ff[wla_pkg::AVG_W-1:0];
         used_ff <= wla_pkg::USED_W'(cnt_ff);
      end
   end

   assign rsp_tdata = wla_pkg::RSP_DATA_W'({used_ff, avg_ff});

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_init && cnt_ff != '0) |=> (divs_ff != '0))
      else $error("zero divisor for nonempty window");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.div_step) && divs_ff != '0)
      |-> (rem_ff < {1'b0, divs_ff}))
      else $error("divider remainder out of range");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (cnt_ff <= wla_pkg::CNT_W'(wla_pkg::RING_DEPTH)))
      else $error("entry count above ring depth");

endmodule
`default_nettype wire

// ===== rtl/windowed_latency_average_top.sv =====
// Windowed latency average.
// req channel: one item per finished session, tdata = {now_ms[47:0], sample_ms[31:0]}.
// The item replaces the oldest of 63 (stamp, duration) ring entries, then the ring
// is walked oldest to newest and entries stamped after now - window are averaged.
// rsp channel: one item per request, tdata = {2'b0, entries_used[5:0], average_ms[31:0]}.
// csr port: index 0 average_mode (0 mean, 1 linear weights), index 1 window_period_ms
// (0 = no age limit, reset 60000). Write only while no request is in progress.
// After a request is accepted the ring is walked (one memory read per cycle), the divider
// is set up, a bit-serial division runs and the output register is loaded once it is
// free. One request is processed at a time and req_tready returns after the output load,
// so no new request is accepted before that load.
// A finished result sits in the output register; a new request may be accepted while
// it waits. If rsp_tready stays low the next result waits in the divider until
// the register frees.
// Synchronous reset empties the ring (valid bits, no clearing pass), sets the oldest
// pointer to zero and restores the register defaults.
`default_nettype none
module windowed_latency_average_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // sample_ms[31:0], now_ms[79:32]
   input  wire logic [wla_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // average_ms[31:0], entries_used[37:32], zero pad
   output logic      [wla_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_wen,
   input  wire logic [wla_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [wla_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   wla_pkg::cmd_type cmd;

   wla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   wla_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
